FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sprb_pkg.sv
// ----------------------------------------------------------------------------
// sprb_pkg
// shared types and codes for the sortable priority ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

package sprb_pkg;

   // operation codes carried by a request transaction
   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_SORT = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // one stored queue entry
   typedef struct packed {
      logic [15:0] conn_id;
      logic [7:0]  prio;
   } entry_type;

   // top level sequencer
   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_POP,
      TOP_SORT
   } top_state_type;

   // sort sequencer
   typedef enum logic [2:0] {
      SORT_IDLE,
      SORT_FIRST,
      SORT_LOAD,
      SORT_CMP,
      SORT_TAIL
   } sort_state_type;

   // memory strobes and completion from the sort engine
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic done;
   } sort_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/sprb_sorter.sv
// ----------------------------------------------------------------------------
// sprb_sorter
// stable bubble sort engine over the occupied ring slots, one compare a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sprb_sorter
   import sprb_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [$clog2(DEPTH)-1:0]   base,
   input  wire logic [$clog2(DEPTH)-1:0]   last,
   input  wire entry_type                  rd_data,
   output sort_ctl_type                    ctl,
   output logic      [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [$clog2(DEPTH)-1:0]   wr_addr,
   output entry_type                       wr_data
);

   localparam int unsigned           IDX_W     = $clog2(DEPTH);
   localparam logic [IDX_W-1:0]      LAST_SLOT = IDX_W'(DEPTH - 1);

   sort_state_type   state_ff, state_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   entry_type        carry_ff, carry_in;
   logic             swapped_ff, swapped_in;

   // slot after p around the ring
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SORT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      last_ff    <= last_in;
      rd_ptr_ff  <= rd_ptr_in;
      wr_ptr_ff  <= wr_ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      carry_ff   <= carry_in;
      swapped_ff <= swapped_in;
   end

   // one pass streams the slots through a carry register; the larger
   // priority is carried forward, ties keep their order
   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      last_in    = last_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      cmp_idx_in = cmp_idx_ff;
      carry_in   = carry_ff;
      swapped_in = swapped_ff;
      ctl        = '0;
      rd_addr    = rd_ptr_ff;
      wr_addr    = wr_ptr_ff;
      wr_data    = carry_ff;

      unique case (state_ff)
         SORT_IDLE: begin
            if (start) begin
               base_in  = base;
               last_in  = last;
               state_in = SORT_FIRST;
            end
         end
         // start of a pass: fetch the oldest slot
         SORT_FIRST: begin
            ctl.rd_en  = 1'b1;
            rd_addr    = base_ff;
            rd_ptr_in  = ring_next(base_ff);
            wr_ptr_in  = base_ff;
            swapped_in = 1'b0;
            state_in   = SORT_LOAD;
         end
         // first slot lands in the carry, fetch the second
         SORT_LOAD: begin
            carry_in   = rd_data;
            ctl.rd_en  = 1'b1;
            rd_ptr_in  = ring_next(rd_ptr_ff);
            cmp_idx_in = IDX_W'(1);
            state_in   = SORT_CMP;
         end
         // compare arriving slot with carry, write back the smaller
         SORT_CMP: begin
            ctl.wr_en = 1'b1;
            wr_ptr_in = ring_next(wr_ptr_ff);
            if (carry_ff.prio > rd_data.prio) begin
               wr_data    = rd_data;
               swapped_in = 1'b1;
            end else begin
               wr_data  = carry_ff;
               carry_in = rd_data;
            end
            if (cmp_idx_ff == last_ff) begin
               state_in = SORT_TAIL;
            end else begin
               ctl.rd_en  = 1'b1;
               rd_ptr_in  = ring_next(rd_ptr_ff);
               cmp_idx_in = cmp_idx_ff + 1'b1;
            end
         end
         // largest of the pass goes to the newest slot
         SORT_TAIL: begin
            ctl.wr_en = 1'b1;
            if (swapped_ff) begin
               state_in = SORT_FIRST;
            end else begin
               ctl.done = 1'b1;
               state_in = SORT_IDLE;
            end
         end
         default: begin
            state_in = SORT_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/sortable_priority_ring_buffer.sv
// ----------------------------------------------------------------------------
// sortable_priority_ring_buffer
// circular queue of connection id / priority entries with an in-place sort
// ----------------------------------------------------------------------------
// Usage: a request transaction carries func (push, pop, sort) with conn_id
// and prio for a push. Every request produces exactly one response
// transaction with the popped entry (zero unless a pop succeeds), a status
// (ok, full, empty) and the occupancy after the operation.
// Response path: push, refused operations, unused codes and a sort of fewer
// than two entries load the response register on acceptance; a pop first
// reads the entry through the registered read of the entry store.
// A sort of n entries runs bubble passes on the single store port pair, one
// compare per cycle: each pass steps through the first, load, compare and
// tail states; up to n passes run, ending after a pass with no swap.
// Throughput: one request at a time; req_stall stays high while a pop or
// sort is in progress.
// Reset: pointers and occupancy go to zero; store contents stay undefined
// and are never read before being written.
// Receiver stall: the response register holds its value and req_stall is
// raised until the response transaction completes.
// ----------------------------------------------------------------------------
`default_nettype none

module sortable_priority_ring_buffer
   import sprb_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [15:0]                  req_conn_id,
   input  wire logic [7:0]                   req_prio,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [15:0]                  rsp_out_conn_id,
   output logic      [7:0]                   rsp_out_prio,
   output logic      [1:0]                   rsp_status,
   output logic      [$clog2(DEPTH+1)-1:0]   rsp_occupancy
);

   localparam int unsigned      IDX_W     = $clog2(DEPTH);
   localparam int unsigned      CNT_W     = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   top_state_type    state_ff, state_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   entry_type        rsp_entry_ff, rsp_entry_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_occ_ff, rsp_occ_in;

   entry_type        mem_ff [DEPTH];
   entry_type        rd_data_ff;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;

   logic             req_accept;
   func_type         func;
   logic             load_now;
   entry_type        load_entry;
   status_type       load_status;
   logic             sort_start;
   logic [IDX_W-1:0] sort_last;
   sort_ctl_type     sort_ctl;
   logic [IDX_W-1:0] sort_rd_addr;
   logic [IDX_W-1:0] sort_wr_addr;
   entry_type        sort_wr_data;

   // slot after p around the ring
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   // request handshake
   assign req_stall  = (state_ff != TOP_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign func       = func_type'(req_func);
   assign sort_last  = IDX_W'(count_ff - CNT_W'(1));

   // sort engine sharing the store ports
   sprb_sorter #(
      .DEPTH (DEPTH)
   ) u_sorter (
      .clock   (clock),
      .reset   (reset),
      .start   (sort_start),
      .base    (rd_idx_ff),
      .last    (sort_last),
      .rd_data (rd_data_ff),
      .ctl     (sort_ctl),
      .rd_addr (sort_rd_addr),
      .wr_addr (sort_wr_addr),
      .wr_data (sort_wr_data)
   );

   // entry store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem_ff[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem_ff[mem_rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_entry_ff  <= rsp_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // sequencer, pointer update and response load
   always_comb begin
      state_in      = state_ff;
      wr_idx_in     = wr_idx_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_entry_in  = rsp_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_idx_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wr_idx_ff;
      mem_wr_data   = '{conn_id: req_conn_id, prio: req_prio};
      sort_start    = 1'b0;
      load_now      = 1'b0;
      load_entry    = '0;
      load_status   = STATUS_OK;

      unique case (state_ff)
         TOP_IDLE: begin
            if (req_accept) begin
               unique case (func)
                  FUNC_PUSH: begin
                     load_now = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        load_status = STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        wr_idx_in = ring_next(wr_idx_ff);
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff == '0) begin
                        load_now    = 1'b1;
                        load_status = STATUS_EMPTY;
                     end else begin
                        mem_rd_en = 1'b1;
                        rd_idx_in = ring_next(rd_idx_ff);
                        count_in  = count_ff - CNT_W'(1);
                        state_in  = TOP_POP;
                     end
                  end
                  FUNC_SORT: begin
                     if (count_ff > CNT_W'(1)) begin
                        sort_start = 1'b1;
                        state_in   = TOP_SORT;
                     end else begin
                        load_now = 1'b1;
                     end
                  end
                  FUNC_NOP: begin
                     load_now = 1'b1;
                  end
                  default: begin
                     load_now = 1'b1;
                  end
               endcase
            end
         end
         // popped entry arrives from the store
         TOP_POP: begin
            load_now   = 1'b1;
            load_entry = rd_data_ff;
            state_in   = TOP_IDLE;
         end
         // store ports belong to the sort engine
         TOP_SORT: begin
            mem_rd_en   = sort_ctl.rd_en;
            mem_rd_addr = sort_rd_addr;
            mem_wr_en   = sort_ctl.wr_en;
            mem_wr_addr = sort_wr_addr;
            mem_wr_data = sort_wr_data;
            if (sort_ctl.done) begin
               load_now = 1'b1;
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase

      // response register is always free when a load happens
      if (load_now) begin
         rsp_valid_in  = 1'b1;
         rsp_entry_in  = load_entry;
         rsp_status_in = load_status;
         rsp_occ_in    = count_in;
      end
   end

   // response ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_conn_id = rsp_entry_ff.conn_id;
   assign rsp_out_prio    = rsp_entry_ff.prio;
   assign rsp_status      = rsp_status_ff;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule

`default_nettype wire

FILE: rtl/sprb_checker.sv
// ----------------------------------------------------------------------------
// sprb_checker
// port level checks for the sortable priority ring buffer
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sprb_checker
   import sprb_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [15:0]                  rsp_out_conn_id,
   input wire logic [7:0]                   rsp_out_prio,
   input wire logic [1:0]                   rsp_status,
   input wire logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy
);

   localparam int unsigned      OCC_W    = $clog2(DEPTH + 1);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

   // occupancy never beyond the ring depth
   `ASSERT_IMPLIES(a_occ_bound, clock, reset, rsp_valid, rsp_occupancy <= FULL_OCC, "occupancy above depth")

   // a refused push only when the ring is full
   `ASSERT_IMPLIES(a_full_refusal, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_occupancy == FULL_OCC && rsp_out_conn_id == '0 && rsp_out_prio == '0, "full refusal inconsistent")

   // a refused pop only when empty, with zero payload
   `ASSERT_IMPLIES(a_empty_refusal, clock, reset, rsp_valid && rsp_status == STATUS_EMPTY, rsp_occupancy == '0 && rsp_out_conn_id == '0 && rsp_out_prio == '0, "empty refusal inconsistent")

   // no new request taken while a response waits on the receiver
   `ASSERT_IMPLIES(a_no_overrun, clock, reset, rsp_valid && rsp_stall, req_stall, "request taken while response stalled")

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_conn_id) && $stable(rsp_out_prio) && $stable(rsp_status) && $stable(rsp_occupancy), "stalled response changed")

endmodule

bind sortable_priority_ring_buffer sprb_checker #(
   .DEPTH (DEPTH)
) u_sprb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_conn_id (rsp_out_conn_id),
   .rsp_out_prio    (rsp_out_prio),
   .rsp_status      (rsp_status),
   .rsp_occupancy   (rsp_occupancy)
);

`default_nettype wire
